FILE: rtl/core/clsu_pkg.sv
// ----------------------------------------------------------------------------
// clsu_pkg
// shared types, instruction codes and target codes of the load/store unit
// ----------------------------------------------------------------------------
package clsu_pkg;

  // default memory address width
  localparam int ADDR_BITS_DFLT = 16;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  // instruction codes
  localparam logic [3:0] FN_LD_RR       = 4'd0;
  localparam logic [3:0] FN_LD_R_HL     = 4'd1;
  localparam logic [3:0] FN_ST_HL_R     = 4'd2;
  localparam logic [3:0] FN_LD_R_IMM    = 4'd3;
  localparam logic [3:0] FN_ST_HL_IMM   = 4'd4;
  localparam logic [3:0] FN_LD_A_BC     = 4'd5;
  localparam logic [3:0] FN_LD_A_DE     = 4'd6;
  localparam logic [3:0] FN_LD_A_HLI    = 4'd7;
  localparam logic [3:0] FN_LD_A_HLD    = 4'd8;
  localparam logic [3:0] FN_ST_BC_A     = 4'd9;
  localparam logic [3:0] FN_ST_DE_A     = 4'd10;
  localparam logic [3:0] FN_ST_HLI_A    = 4'd11;
  localparam logic [3:0] FN_ST_HLD_A    = 4'd12;
  localparam logic [3:0] FN_LD_PAIR_IMM = 4'd13;
  localparam logic [3:0] FN_ST_IMM_SP   = 4'd14;
  localparam logic [3:0] FN_NOP         = 4'd15;

  // byte register codes
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_A = 3'd7;

  // pair select code of the stack pointer
  localparam logic [1:0] PSEL_SP = 2'd3;

  // result target codes beyond the byte registers
  localparam logic [3:0] TGT_BC  = 4'd8;
  localparam logic [3:0] TGT_HL  = 4'd10;
  localparam logic [3:0] TGT_MEM = 4'd12;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  dst_reg;
    logic [2:0]  src_reg;
    logic [1:0]  pair_sel;
    logic [15:0] imm;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] value;
    logic [15:0] mem_addr;
    logic        last;
  } out_item_t;

  // where the memory address of an instruction comes from
  typedef enum logic [2:0] {
    ADDR_NONE,
    ADDR_HL,
    ADDR_BC,
    ADDR_DE,
    ADDR_IMM
  } addr_src_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  dst_reg;
    logic [2:0]  src_reg;
    logic [1:0]  pair_sel;
    logic [15:0] imm;
    addr_src_t   addr_src;
    logic        mem_rd;
    logic        two_res;
  } op_t;

endpackage

FILE: rtl/core/clsu_front.sv
// ----------------------------------------------------------------------------
// clsu_front
// input handshake and classification of load/store requests
// ----------------------------------------------------------------------------
module clsu_front
  import clsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  input  logic     clr_busy,
  output logic     q_push,
  output op_t      q_op
);

  logic accept;
  logic busy_r;

  // hold register set in reset so stall never leaves reset low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign in_stall = q_full || clr_busy || busy_r;
  assign accept   = in_valid && !in_stall;
  // no-op codes are taken and dropped
  assign q_push   = accept && (in_item.func != FN_NOP);

  always_comb begin
    q_op.func     = in_item.func;
    q_op.dst_reg  = in_item.dst_reg;
    q_op.src_reg  = in_item.src_reg;
    q_op.pair_sel = in_item.pair_sel;
    q_op.imm      = in_item.imm;
    q_op.addr_src = ADDR_NONE;
    q_op.mem_rd   = 1'b0;
    q_op.two_res  = 1'b0;
    case (in_item.func)
      FN_LD_R_HL: begin
        q_op.addr_src = ADDR_HL;
        q_op.mem_rd   = 1'b1;
      end
      FN_ST_HL_R, FN_ST_HL_IMM: begin
        q_op.addr_src = ADDR_HL;
      end
      FN_LD_A_BC: begin
        q_op.addr_src = ADDR_BC;
        q_op.mem_rd   = 1'b1;
      end
      FN_LD_A_DE: begin
        q_op.addr_src = ADDR_DE;
        q_op.mem_rd   = 1'b1;
      end
      FN_LD_A_HLI, FN_LD_A_HLD: begin
        q_op.addr_src = ADDR_HL;
        q_op.mem_rd   = 1'b1;
        q_op.two_res  = 1'b1;
      end
      FN_ST_BC_A: begin
        q_op.addr_src = ADDR_BC;
      end
      FN_ST_DE_A: begin
        q_op.addr_src = ADDR_DE;
      end
      FN_ST_HLI_A, FN_ST_HLD_A: begin
        q_op.addr_src = ADDR_HL;
        q_op.two_res  = 1'b1;
      end
      FN_ST_IMM_SP: begin
        q_op.addr_src = ADDR_IMM;
        q_op.two_res  = 1'b1;
      end
      default: begin
        q_op.addr_src = ADDR_NONE;
      end
    endcase
  end

endmodule

FILE: rtl/core/clsu_queue.sv
// ----------------------------------------------------------------------------
// clsu_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module clsu_queue
  import clsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  op_t           entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: rtl/core/clsu_back.sv
// ----------------------------------------------------------------------------
// clsu_back
// execution: register file, byte memory, issue and write-back stages
// ----------------------------------------------------------------------------
module clsu_back
  import clsu_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  output logic      clr_busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int MEM_DEPTH = 2 ** ADDR_BITS;

  // architectural state
  logic [7:0]  regs_r   [8];
  logic [7:0]  regs_nxt [8];
  logic [15:0] sp_r;
  logic [15:0] sp_nxt;

  // byte memory
  logic [7:0]           mem [MEM_DEPTH];
  logic [7:0]           ram_q_r;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_wa;
  logic [7:0]           mem_wd;
  logic                 rd_en;

  // clearing pass
  logic                 clr_busy_r;
  logic [ADDR_BITS-1:0] clr_addr_r;

  // issue stage
  logic [15:0]          x_pair;
  logic [ADDR_BITS-1:0] x_addr;

  // write-back stage
  logic                 w_valid_r;
  logic                 w_phase_r;
  op_t                  w_op_r;
  logic [ADDR_BITS-1:0] w_addr_r;
  logic                 byp_hit_r;
  logic [7:0]           byp_data_r;
  logic [7:0]           md;
  logic [15:0]          hl_cur;
  logic [15:0]          hl_step;
  logic                 out_free;
  logic                 w_fire;
  logic                 w_final;

  // write intents of the current write-back step
  out_item_t            res;
  logic                 rf_we;
  logic [2:0]           rf_idx;
  logic [7:0]           rf_data;
  logic                 pair_we;
  logic                 sp_we;
  logic                 m_we;
  logic [ADDR_BITS-1:0] m_wa;
  logic [7:0]           m_wd;

  // output register
  logic                 out_valid_r;
  out_item_t            out_item_r;

  assign clr_busy  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign out_free = !out_valid_r || !out_stall;
  assign w_fire   = w_valid_r && out_free;
  assign w_final  = w_fire && (!w_op_r.two_res || w_phase_r);
  assign q_pop    = q_valid && !clr_busy_r && (!w_valid_r || w_final);
  assign rd_en    = q_pop && q_op.mem_rd;

  assign md      = byp_hit_r ? byp_data_r : ram_q_r;
  assign hl_cur  = {regs_r[REG_H], regs_r[REG_L]};
  assign hl_step = (w_op_r.func inside {FN_LD_A_HLI, FN_ST_HLI_A})
                   ? hl_cur + 16'd1 : hl_cur - 16'd1;

  // address from the register view after this cycle's write-back
  always_comb begin
    case (q_op.addr_src)
      ADDR_HL:  x_pair = {regs_nxt[REG_H], regs_nxt[REG_L]};
      ADDR_BC:  x_pair = {regs_nxt[REG_B], regs_nxt[REG_C]};
      ADDR_DE:  x_pair = {regs_nxt[REG_D], regs_nxt[REG_E]};
      ADDR_IMM: x_pair = q_op.imm;
      default:  x_pair = '0;
    endcase
  end
  assign x_addr = x_pair[ADDR_BITS-1:0];

  // write-back step: result and state writes
  always_comb begin
    res     = '0;
    rf_we   = 1'b0;
    rf_idx  = w_op_r.dst_reg;
    rf_data = '0;
    pair_we = 1'b0;
    sp_we   = 1'b0;
    m_we    = 1'b0;
    m_wa    = w_addr_r;
    m_wd    = '0;
    res.last = 1'b1;
    if (!w_phase_r) begin
      case (w_op_r.func)
        FN_LD_RR: begin
          rf_we   = 1'b1;
          rf_data = regs_r[w_op_r.src_reg];
        end
        FN_LD_R_HL: begin
          rf_we   = 1'b1;
          rf_data = md;
        end
        FN_ST_HL_R: begin
          m_we = 1'b1;
          m_wd = regs_r[w_op_r.src_reg];
        end
        FN_LD_R_IMM: begin
          rf_we   = 1'b1;
          rf_data = w_op_r.imm[7:0];
        end
        FN_ST_HL_IMM: begin
          m_we = 1'b1;
          m_wd = w_op_r.imm[7:0];
        end
        FN_LD_A_BC, FN_LD_A_DE, FN_LD_A_HLI, FN_LD_A_HLD: begin
          rf_we   = 1'b1;
          rf_idx  = REG_A;
          rf_data = md;
        end
        FN_ST_BC_A, FN_ST_DE_A, FN_ST_HLI_A, FN_ST_HLD_A: begin
          m_we = 1'b1;
          m_wd = regs_r[REG_A];
        end
        FN_LD_PAIR_IMM: begin
          if (w_op_r.pair_sel == PSEL_SP) begin
            sp_we = 1'b1;
          end else begin
            pair_we = 1'b1;
          end
        end
        FN_ST_IMM_SP: begin
          m_we = 1'b1;
          m_wd = sp_r[7:0];
        end
        default: begin
          m_we = 1'b0;
        end
      endcase
      if (rf_we) begin
        res.target = {1'b0, rf_idx};
        res.value  = 16'(rf_data);
        res.mem_addr = w_op_r.mem_rd ? 16'(w_addr_r) : 16'd0;
      end else if (m_we) begin
        res.target   = TGT_MEM;
        res.value    = 16'(m_wd);
        res.mem_addr = 16'(w_addr_r);
      end else begin
        res.target = TGT_BC + {2'b00, w_op_r.pair_sel};
        res.value  = w_op_r.imm;
      end
      res.last = !w_op_r.two_res;
    end else begin
      if (w_op_r.func == FN_ST_IMM_SP) begin
        // high byte of sp one address up
        m_we         = 1'b1;
        m_wa         = w_addr_r + ADDR_BITS'(1);
        m_wd         = sp_r[15:8];
        res.target   = TGT_MEM;
        res.value    = 16'(m_wd);
        res.mem_addr = 16'(m_wa);
      end else begin
        res.target = TGT_HL;
        res.value  = hl_step;
      end
    end
  end

  // next register state, also the forwarding view for issue
  always_comb begin
    regs_nxt = regs_r;
    sp_nxt   = sp_r;
    if (w_fire) begin
      if (rf_we) begin
        regs_nxt[rf_idx] = rf_data;
      end
      if (pair_we) begin
        regs_nxt[{w_op_r.pair_sel[1:0], 1'b0}] = w_op_r.imm[15:8];
        regs_nxt[{w_op_r.pair_sel[1:0], 1'b1}] = w_op_r.imm[7:0];
      end
      if (sp_we) begin
        sp_nxt = w_op_r.imm;
      end
      if (w_phase_r && (w_op_r.func != FN_ST_IMM_SP)) begin
        regs_nxt[REG_H] = hl_step[15:8];
        regs_nxt[REG_L] = hl_step[7:0];
      end
    end
  end

  // memory write port: clearing pass or write-back
  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = w_fire && m_we;
      mem_wa = m_wa;
      mem_wd = m_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      ram_q_r <= mem[x_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      regs_r      <= '{default: '0};
      sp_r        <= '0;
      w_valid_r   <= 1'b0;
      w_phase_r   <= 1'b0;
      byp_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      regs_r <= regs_nxt;
      sp_r   <= sp_nxt;
      if (q_pop) begin
        w_valid_r <= 1'b1;
        w_phase_r <= 1'b0;
        // read and write of the same byte in one cycle
        byp_hit_r <= mem_we && (mem_wa == x_addr);
      end else if (w_final) begin
        w_valid_r <= 1'b0;
        w_phase_r <= 1'b0;
      end else if (w_fire) begin
        w_phase_r <= 1'b1;
      end
      if (out_free) begin
        out_valid_r <= w_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_op_r     <= q_op;
      w_addr_r   <= x_addr;
      byp_data_r <= mem_wd;
    end
    if (w_fire) begin
      out_item_r <= res;
    end
  end

  a_phase_two_res: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r && w_phase_r |-> w_op_r.two_res)
    else $error("second write-back step on a single-result request");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !w_valid_r && !out_valid_r)
    else $error("request in flight during memory clearing");

  a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !out_item_r.last |=> out_valid_r && out_item_r.last)
    else $error("second result of a request did not follow its first");

endmodule

FILE: rtl/core/cpu_load_store_unit.sv
// ----------------------------------------------------------------------------
// cpu_load_store_unit
// 8-bit load/store instruction unit with register file and byte memory
// ----------------------------------------------------------------------------
//
//  channel   ports                                  direction  payload
//  input     in_valid, in_stall, in_item            in         in_item_t
//  result    out_valid, out_stall, out_item         out        out_item_t
//
//  - one request per cycle sustained while the output does not stall;
//    requests with two results (hl+ and hl- forms, sp store) hold the
//    write-back stage for a second step, set by the single output register
//    and the single memory write port
//  - the first result follows the queue entry, written at the accepting edge,
//    then issue with memory read, then write-back into the output register
//  - after reset a clearing pass zeroes the byte memory, during which in_stall
//    stays high
//  - outside the clearing pass in_stall rises only when the four-entry queue
//    is full; a stalled output backs up the write-back stage, then issue, then
//    the queue
//
module cpu_load_store_unit
  import clsu_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  // request channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // front to queue
  logic q_push;
  op_t  q_push_op;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_valid;
  op_t  q_head_op;

  // memory clearing in progress
  logic clr_busy;

  // front: handshake and classification, no-op codes dropped here
  clsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_op     (q_push_op)
  );

  // decouples front stalls from back stalls
  clsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head_op)
  );

  // back: address issue with forwarding, memory, write-back and result register
  clsu_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_head_op),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: sim/cpu_load_store_unit_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_load_store_unit_chk
// watches both channels of the load/store unit, keeps a shadow register file,
// stack pointer and byte memory, and checks every result against the
// predicted architectural writes in order
// ----------------------------------------------------------------------------
module cpu_load_store_unit_chk
  import clsu_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatches,
  output int        outstanding
);

  localparam int          MEM_WORDS = 1 << ADDR_BITS;
  localparam logic [15:0] ADDR_MASK = 16'(MEM_WORDS - 1);

  logic [7:0]  gpr [8];
  logic [15:0] sp_shadow;
  logic [7:0]  mem_shadow [MEM_WORDS];
  out_item_t   pending_writes [$];
  out_item_t   oldest;

  // memory is cleared by reset
  initial begin
    mismatches  = 0;
    outstanding = 0;
    sp_shadow   = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (mem_shadow[i]) mem_shadow[i] = '0;
  end

  task automatic flag(input string msg);
    $display("%0t  %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag($sformatf("%s mismatch: got %h, expected %h", name, got, want));
  endtask

  task automatic expect_write(input logic [3:0] tgt, input logic [15:0] val,
                              input logic [15:0] addr, input logic fin);
    out_item_t w;
    w.target   = tgt;
    w.value    = val;
    w.mem_addr = addr;
    w.last     = fin;
    pending_writes.push_back(w);
  endtask

  // one load instruction: update shadow state, queue its writes in order
  task automatic execute_load(input in_item_t req);
    logic [15:0] hl;
    logic [15:0] step;
    logic [15:0] ptr;
    hl   = {gpr[REG_H], gpr[REG_L]};
    step = (req.func inside {FN_LD_A_HLI, FN_ST_HLI_A}) ? 16'h0001 : 16'hFFFF;
    case (req.func)
      FN_LD_RR: begin
        gpr[req.dst_reg] = gpr[req.src_reg];
        expect_write({1'b0, req.dst_reg}, {8'h00, gpr[req.dst_reg]}, '0, 1'b1);
      end
      FN_LD_R_HL: begin
        ptr = hl & ADDR_MASK;
        gpr[req.dst_reg] = mem_shadow[ptr];
        expect_write({1'b0, req.dst_reg}, {8'h00, gpr[req.dst_reg]}, ptr, 1'b1);
      end
      FN_ST_HL_R: begin
        ptr = hl & ADDR_MASK;
        mem_shadow[ptr] = gpr[req.src_reg];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b1);
      end
      FN_LD_R_IMM: begin
        gpr[req.dst_reg] = req.imm[7:0];
        expect_write({1'b0, req.dst_reg}, {8'h00, gpr[req.dst_reg]}, '0, 1'b1);
      end
      FN_ST_HL_IMM: begin
        ptr = hl & ADDR_MASK;
        mem_shadow[ptr] = req.imm[7:0];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b1);
      end
      FN_LD_A_BC, FN_LD_A_DE: begin
        ptr = (req.func == FN_LD_A_BC) ? {gpr[REG_B], gpr[REG_C]} : {gpr[REG_D], gpr[REG_E]};
        ptr = ptr & ADDR_MASK;
        gpr[REG_A] = mem_shadow[ptr];
        expect_write({1'b0, REG_A}, {8'h00, gpr[REG_A]}, ptr, 1'b1);
      end
      FN_LD_A_HLI, FN_LD_A_HLD: begin
        ptr = hl & ADDR_MASK;
        gpr[REG_A] = mem_shadow[ptr];
        expect_write({1'b0, REG_A}, {8'h00, gpr[REG_A]}, ptr, 1'b0);
        hl = hl + step;
        {gpr[REG_H], gpr[REG_L]} = hl;
        expect_write(TGT_HL, hl, '0, 1'b1);
      end
      FN_ST_BC_A, FN_ST_DE_A: begin
        ptr = (req.func == FN_ST_BC_A) ? {gpr[REG_B], gpr[REG_C]} : {gpr[REG_D], gpr[REG_E]};
        ptr = ptr & ADDR_MASK;
        mem_shadow[ptr] = gpr[REG_A];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b1);
      end
      FN_ST_HLI_A, FN_ST_HLD_A: begin
        ptr = hl & ADDR_MASK;
        mem_shadow[ptr] = gpr[REG_A];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b0);
        hl = hl + step;
        {gpr[REG_H], gpr[REG_L]} = hl;
        expect_write(TGT_HL, hl, '0, 1'b1);
      end
      FN_LD_PAIR_IMM: begin
        if (req.pair_sel == PSEL_SP) begin
          sp_shadow = req.imm;
        end else begin
          gpr[{req.pair_sel, 1'b0}] = req.imm[15:8];
          gpr[{req.pair_sel, 1'b1}] = req.imm[7:0];
        end
        expect_write(TGT_BC + {2'b00, req.pair_sel}, req.imm, '0, 1'b1);
      end
      FN_ST_IMM_SP: begin
        // little-endian, second byte address wraps
        ptr = req.imm & ADDR_MASK;
        mem_shadow[ptr] = sp_shadow[7:0];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b0);
        ptr = (req.imm + 16'h0001) & ADDR_MASK;
        mem_shadow[ptr] = sp_shadow[15:8];
        expect_write(TGT_MEM, {8'h00, mem_shadow[ptr]}, ptr, 1'b1);
      end
      default: begin
        // no operation, nothing written
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) execute_load(in_item);
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          flag($sformatf("result with nothing pending: target %0d value %h addr %h last %b",
                         out_item.target, out_item.value, out_item.mem_addr, out_item.last));
        end else begin
          oldest = pending_writes.pop_front();
          compare_field("target", {12'h000, out_item.target}, {12'h000, oldest.target});
          compare_field("value", out_item.value, oldest.value);
          compare_field("mem_addr", out_item.mem_addr, oldest.mem_addr);
          compare_field("last", {15'h0000, out_item.last}, {15'h0000, oldest.last});
        end
      end
      outstanding = pending_writes.size();
    end
  end

endmodule

FILE: sim/cpu_load_store_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_load_store_unit_tb
// drives load/store requests into the unit with random gaps and result-side
// stalls; a checker beside the unit predicts and compares every write
// ----------------------------------------------------------------------------
module cpu_load_store_unit_tb;
  import clsu_pkg::*;

  // the memory clearing pass after reset runs over every byte address
  localparam int WATCHDOG_CYCLES = 1_000_000;
  localparam int RANDOM_LOADS    = 2000;
  localparam int IDLE_PCT        = 27;
  localparam int DRAIN_CYCLES    = 16;

  // spare byte register slot, not part of any pair
  localparam logic [2:0] REG_SPARE = 3'd6;

  // pair select codes for the 16-bit immediate load
  localparam logic [1:0] PSEL_BC = 2'd0;
  localparam logic [1:0] PSEL_DE = 2'd1;
  localparam logic [1:0] PSEL_HL = 2'd2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // quiet turns off all idling on both sides
  logic quiet;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;

  cpu_load_store_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  cpu_load_store_unit_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: stall in about a quarter of the cycles unless quiet
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog, sized for the clearing pass plus a slow run several times over
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t load_op(input logic [3:0] fn, input logic [2:0] dst,
                                       input logic [2:0] src, input logic [1:0] psel,
                                       input logic [15:0] imm);
    in_item_t r;
    r.func     = fn;
    r.dst_reg  = dst;
    r.src_reg  = src;
    r.pair_sel = psel;
    r.imm      = imm;
    return r;
  endfunction

  // addresses kept in small windows so stores and loads meet often,
  // including the top of memory where hl+ and the sp store wrap
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1, 2:    return 16'hFFF8 + 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic in_item_t random_load();
    in_item_t r;
    int       roll;
    roll       = $urandom_range(0, 99);
    r.dst_reg  = 3'($urandom);
    r.src_reg  = 3'($urandom);
    r.pair_sel = 2'($urandom);
    r.imm      = 16'($urandom);
    // a few no-ops, extra pair loads to keep bc/de/hl in the windows
    if (roll < 3) r.func = FN_NOP;
    else if (roll < 18) r.func = FN_LD_PAIR_IMM;
    else r.func = 4'($urandom_range(0, 14));
    if (r.func == FN_LD_PAIR_IMM && r.pair_sel != PSEL_SP && roll % 5 != 0)
      r.imm = pick_addr();
    if (r.func == FN_ST_IMM_SP) r.imm = pick_addr();
    return r;
  endfunction

  // present one request at the falling edge, return once it is taken
  task automatic issue(input in_item_t req);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stimulus
    in_item_t req;
    int       loads;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: pair loads at the extremes
    issue(load_op(FN_LD_PAIR_IMM, REG_B, REG_B, PSEL_BC, 16'hFFFF));
    issue(load_op(FN_LD_PAIR_IMM, REG_B, REG_B, PSEL_DE, 16'h0000));
    issue(load_op(FN_LD_PAIR_IMM, REG_B, REG_B, PSEL_HL, 16'hFFFF));
    issue(load_op(FN_LD_PAIR_IMM, REG_B, REG_B, PSEL_SP, 16'hA55A));
    // immediate store at the top address, upper immediate byte ignored
    issue(load_op(FN_ST_HL_IMM, REG_B, REG_B, PSEL_BC, 16'h12FF));
    // hl+ wraps ffff to 0000, hl- wraps back
    issue(load_op(FN_LD_A_HLI, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_HLD_A, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_A_HLD, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_HLI_A, REG_B, REG_B, PSEL_BC, 16'h0000));
    // sp store at ffff: high byte lands at 0000
    issue(load_op(FN_ST_IMM_SP, REG_B, REG_B, PSEL_BC, 16'hFFFF));
    // accumulator through bc and de
    issue(load_op(FN_LD_A_BC, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_A_DE, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_BC_A, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_DE_A, REG_B, REG_B, PSEL_BC, 16'h0000));
    // spare register slot as destination and source
    issue(load_op(FN_LD_R_IMM, REG_SPARE, REG_B, PSEL_BC, 16'hFF80));
    issue(load_op(FN_LD_RR, REG_A, REG_SPARE, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_HL_R, REG_B, REG_SPARE, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_R_HL, REG_SPARE, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_RR, REG_B, REG_B, PSEL_BC, 16'h0000));
    // no-op with every field at its top value
    issue(load_op(FN_NOP, REG_A, REG_A, PSEL_SP, 16'hFFFF));
    // hl built from byte loads, then hl- wraps 0000 to ffff
    issue(load_op(FN_LD_R_IMM, REG_H, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_R_IMM, REG_L, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_A_HLD, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_ST_IMM_SP, REG_B, REG_B, PSEL_BC, 16'h0000));
    issue(load_op(FN_LD_PAIR_IMM, REG_B, REG_B, PSEL_SP, 16'h0000));

    // random part, with a long stretch free of gaps and stalls
    loads = 0;
    while (loads < RANDOM_LOADS) begin
      quiet = (loads >= 700 && loads < 1000);
      req   = random_load();
      if (req.func != FN_NOP) loads++;
      issue(req);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // wait for every pending write, then give stray results a chance to show
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/clsu_pkg.sv
rtl/core/clsu_front.sv
rtl/core/clsu_queue.sv
rtl/core/clsu_back.sv
rtl/core/cpu_load_store_unit.sv
sim/cpu_load_store_unit_chk.sv
sim/cpu_load_store_unit_tb.sv
